[src/bftm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftm_pkg
// Shared sizes, codes, types and the command/status bundles of the tape
// machine controller and datapath.
// ----------------------------------------------------------------------------
package bftm_pkg;

	localparam int TAPE_CELLS    = 30000;
	localparam int PROGRAM_DEPTH = 4096;
	localparam int INPUT_DEPTH   = 1024;
	localparam int NEST_LIMIT    = 64;
	localparam int DUMP_CELLS    = 10;

	localparam int TP_W = $clog2(TAPE_CELLS);
	localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
	localparam int PA_W = $clog2(PROGRAM_DEPTH);
	localparam int IL_W = $clog2(INPUT_DEPTH + 1);
	localparam int IA_W = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
	localparam int ND_W = $clog2(NEST_LIMIT + 1);
	localparam int NA_W = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
	localparam int DC_W = (DUMP_CELLS > 1) ? $clog2(DUMP_CELLS) : 1;

	typedef logic [TP_W-1:0] tp_t;
	typedef logic [PC_W-1:0] pc_t;
	typedef logic [PA_W-1:0] pa_t;
	typedef logic [IL_W-1:0] il_t;
	typedef logic [IA_W-1:0] ia_t;
	typedef logic [ND_W-1:0] nd_t;
	typedef logic [NA_W-1:0] na_t;
	typedef logic [DC_W-1:0] dc_t;

	localparam tp_t TP_LAST   = tp_t'(TAPE_CELLS - 1);
	localparam pc_t PROG_FULL = pc_t'(PROGRAM_DEPTH);
	localparam il_t IN_FULL   = il_t'(INPUT_DEPTH);
	localparam nd_t NEST_FULL = nd_t'(NEST_LIMIT);
	localparam dc_t DUMP_LAST = dc_t'(DUMP_CELLS - 1);

	// Item functions.
	localparam logic [1:0] FN_LOADP = 2'd0;
	localparam logic [1:0] FN_LOADI = 2'd1;
	localparam logic [1:0] FN_EXEC  = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_END      = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Instruction characters.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_RBR   = 8'h5D;

	typedef struct packed {
		logic capture;   // latch the accepted input item
		logic sweep;     // clear one tape cell and reset machine registers
		logic op;        // perform the latched load or execute operation
		logic link;      // write the back link of a bracket pair
		logic dump_rd;   // tape read port addressed by the dump counter
		logic dump_inc;  // advance the dump counter
		logic out_load;  // load the output register
		logic out_dump;  // output register takes a dumped cell
	} bftm_cmd_t;

	typedef struct packed {
		logic need_link;
		logic dump;
		logic sweep_last;
		logic dump_last;
	} bftm_stat_t;

endpackage

[src/bftm_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftm_dpath
// Datapath of the tape machine: tape, program, bracket match, nest stack and
// input memories, machine registers and the output register.
// ----------------------------------------------------------------------------
module bftm_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bftm_pkg::bftm_cmd_t   cmd,
	input  logic [9:0]            in_bits,
	output bftm_pkg::bftm_stat_t  stat,
	output logic [7:0]            m_tdata,
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	// Memories
	logic [7:0]      tape_mem  [bftm_pkg::TAPE_CELLS];
	logic [7:0]      prog_mem  [bftm_pkg::PROGRAM_DEPTH];
	bftm_pkg::pa_t   bm_mem    [bftm_pkg::PROGRAM_DEPTH];
	bftm_pkg::pa_t   stack_mem [bftm_pkg::NEST_LIMIT];
	logic [7:0]      in_mem    [bftm_pkg::INPUT_DEPTH];

	logic [7:0]      tape_rd_q;
	logic [7:0]      prog_rd_q;
	bftm_pkg::pa_t   bm_rd_q;
	bftm_pkg::pa_t   stack_rd_q;
	logic [7:0]      in_rd_q;

	// Machine registers
	logic [1:0]      func_q;
	logic [7:0]      data_q;
	bftm_pkg::tp_t   tp_q,    tp_d;
	bftm_pkg::pc_t   pc_q,    pc_d;
	bftm_pkg::pc_t   len_q,   len_d;
	bftm_pkg::nd_t   depth_q, depth_d;
	bftm_pkg::il_t   inlen_q, inlen_d;
	bftm_pkg::il_t   rdpos_q, rdpos_d;
	logic            mism_q,  mism_d;
	bftm_pkg::tp_t   sweep_cnt_q;
	bftm_pkg::dc_t   dump_cnt_q;
	logic [1:0]      st_q,    st_d;
	logic [7:0]      byte_q,  byte_d;
	logic            has_q,   has_d;
	bftm_pkg::pa_t   link_addr_q;
	bftm_pkg::pa_t   link_data_q;

	logic            prog_we, stack_we, bm_we, in_we, tape_we;
	bftm_pkg::pa_t   pos;
	bftm_pkg::pa_t   bm_waddr, bm_wdata;
	bftm_pkg::tp_t   tape_waddr, tape_raddr;
	logic [7:0]      tape_wdata;
	logic            need_link, dump_go;
	logic            dump_oob;

	assign pos        = len_q[bftm_pkg::PA_W-1:0];
	assign tape_raddr = cmd.dump_rd ? bftm_pkg::tp_t'(dump_cnt_q) : tp_q;
	assign dump_oob   = (32'(dump_cnt_q) >= 32'(bftm_pkg::TAPE_CELLS));

	assign stat.need_link  = need_link;
	assign stat.dump       = dump_go;
	assign stat.sweep_last = (sweep_cnt_q == bftm_pkg::TP_LAST);
	assign stat.dump_last  = (dump_cnt_q == bftm_pkg::DUMP_LAST);

	always_comb begin
		tp_d       = tp_q;
		pc_d       = pc_q;
		len_d      = len_q;
		depth_d    = depth_q;
		inlen_d    = inlen_q;
		rdpos_d    = rdpos_q;
		mism_d     = mism_q;
		st_d       = st_q;
		byte_d     = byte_q;
		has_d      = has_q;
		prog_we    = 1'b0;
		stack_we   = 1'b0;
		bm_we      = 1'b0;
		in_we      = 1'b0;
		tape_we    = 1'b0;
		need_link  = 1'b0;
		dump_go    = 1'b0;
		bm_waddr   = pos;
		bm_wdata   = stack_rd_q;
		tape_waddr = tp_q;
		tape_wdata = 8'd0;
		if (cmd.sweep) begin
			tape_we    = 1'b1;
			tape_waddr = sweep_cnt_q;
			tp_d       = '0;
			pc_d       = '0;
			len_d      = '0;
			depth_d    = '0;
			inlen_d    = '0;
			rdpos_d    = '0;
			mism_d     = 1'b0;
			st_d       = bftm_pkg::ST_OK;
			byte_d     = 8'd0;
			has_d      = 1'b0;
		end else if (cmd.link) begin
			bm_we    = 1'b1;
			bm_waddr = link_addr_q;
			bm_wdata = link_data_q;
		end else if (cmd.op) begin
			st_d   = bftm_pkg::ST_OK;
			byte_d = 8'd0;
			has_d  = 1'b0;
			case (func_q)
				bftm_pkg::FN_LOADP: begin
					if (len_q >= bftm_pkg::PROG_FULL) begin
						st_d = bftm_pkg::ST_FULL;
					end else if (data_q == bftm_pkg::CH_LBR) begin
						if (depth_q >= bftm_pkg::NEST_FULL) begin
							st_d = bftm_pkg::ST_FULL;
						end else begin
							stack_we = 1'b1;
							depth_d  = depth_q + bftm_pkg::nd_t'(1);
							prog_we  = 1'b1;
							len_d    = len_q + bftm_pkg::pc_t'(1);
						end
					end else if (data_q == bftm_pkg::CH_RBR) begin
						prog_we = 1'b1;
						len_d   = len_q + bftm_pkg::pc_t'(1);
						if (depth_q == '0) begin
							mism_d = 1'b1;
							st_d   = bftm_pkg::ST_MISMATCH;
						end else begin
							depth_d   = depth_q - bftm_pkg::nd_t'(1);
							bm_we     = 1'b1;
							need_link = 1'b1;
						end
					end else begin
						prog_we = 1'b1;
						len_d   = len_q + bftm_pkg::pc_t'(1);
					end
				end
				bftm_pkg::FN_LOADI: begin
					if (inlen_q >= bftm_pkg::IN_FULL) begin
						st_d = bftm_pkg::ST_FULL;
					end else begin
						in_we   = 1'b1;
						inlen_d = inlen_q + bftm_pkg::il_t'(1);
					end
				end
				bftm_pkg::FN_EXEC: begin
					if (mism_q || depth_q != '0) begin
						st_d = bftm_pkg::ST_MISMATCH;
					end else if (pc_q >= len_q) begin
						st_d = bftm_pkg::ST_END;
					end else begin
						pc_d = pc_q + bftm_pkg::pc_t'(1);
						case (prog_rd_q)
							bftm_pkg::CH_LT: begin
								tp_d = (tp_q == '0) ? bftm_pkg::TP_LAST
									: tp_q - bftm_pkg::tp_t'(1);
							end
							bftm_pkg::CH_GT: begin
								tp_d = (tp_q == bftm_pkg::TP_LAST) ? '0
									: tp_q + bftm_pkg::tp_t'(1);
							end
							bftm_pkg::CH_PLUS: begin
								tape_we    = 1'b1;
								tape_wdata = tape_rd_q + 8'd1;
							end
							bftm_pkg::CH_MINUS: begin
								tape_we    = 1'b1;
								tape_wdata = tape_rd_q - 8'd1;
							end
							bftm_pkg::CH_COMMA: begin
								tape_we = 1'b1;
								if (rdpos_q < inlen_q) begin
									tape_wdata = in_rd_q;
									rdpos_d    = rdpos_q + bftm_pkg::il_t'(1);
								end
							end
							bftm_pkg::CH_DOT: begin
								byte_d = tape_rd_q;
								has_d  = 1'b1;
							end
							bftm_pkg::CH_HASH: begin
								dump_go = 1'b1;
							end
							bftm_pkg::CH_LBR: begin
								if (tape_rd_q == 8'd0) begin
									pc_d = bftm_pkg::pc_t'(bm_rd_q) + bftm_pkg::pc_t'(1);
								end
							end
							bftm_pkg::CH_RBR: begin
								if (tape_rd_q != 8'd0) begin
									pc_d = bftm_pkg::pc_t'(bm_rd_q) + bftm_pkg::pc_t'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q        <= '0;
			pc_q        <= '0;
			len_q       <= '0;
			depth_q     <= '0;
			inlen_q     <= '0;
			rdpos_q     <= '0;
			mism_q      <= 1'b0;
			sweep_cnt_q <= '0;
			dump_cnt_q  <= '0;
		end else begin
			tp_q    <= tp_d;
			pc_q    <= pc_d;
			len_q   <= len_d;
			depth_q <= depth_d;
			inlen_q <= inlen_d;
			rdpos_q <= rdpos_d;
			mism_q  <= mism_d;
			if (cmd.sweep) begin
				sweep_cnt_q <= stat.sweep_last ? '0 : sweep_cnt_q + bftm_pkg::tp_t'(1);
			end
			if (cmd.op) begin
				dump_cnt_q <= '0;
			end else if (cmd.dump_inc) begin
				dump_cnt_q <= dump_cnt_q + bftm_pkg::dc_t'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		st_q   <= st_d;
		byte_q <= byte_d;
		has_q  <= has_d;
		if (cmd.capture) begin
			func_q <= in_bits[1:0];
			data_q <= in_bits[9:2];
		end
		if (cmd.op) begin
			link_addr_q <= stack_rd_q;
			link_data_q <= pos;
		end
		if (cmd.out_load) begin
			if (cmd.out_dump) begin
				m_tdata <= dump_oob ? 8'd0 : tape_rd_q;
				m_tuser <= {bftm_pkg::ST_OK, 1'b1};
				m_tlast <= stat.dump_last;
			end else begin
				m_tdata <= byte_q;
				m_tuser <= {st_q, has_q};
				m_tlast <= 1'b1;
			end
		end
	end

	// Memory ports, read data registered
	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		tape_rd_q <= tape_mem[tape_raddr];
	end

	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[pos] <= data_q;
		end
		prog_rd_q <= prog_mem[pc_q[bftm_pkg::PA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		bm_rd_q <= bm_mem[pc_q[bftm_pkg::PA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[bftm_pkg::na_t'(depth_q)] <= pos;
		end
		stack_rd_q <= stack_mem[bftm_pkg::na_t'(depth_q - bftm_pkg::nd_t'(1))];
	end

	always_ff @(posedge clk) begin
		if (in_we) begin
			in_mem[inlen_q[bftm_pkg::IA_W-1:0]] <= data_q;
		end
		in_rd_q <= in_mem[rdpos_q[bftm_pkg::IA_W-1:0]];
	end

`ifndef NO_ASSERTIONS
	a_rdpos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rdpos_q <= inlen_q)
		else $error("input read position passed the input length");

	a_depth_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= bftm_pkg::NEST_FULL)
		else $error("nest depth exceeds the stack size");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= bftm_pkg::PROG_FULL)
		else $error("program length exceeds the program store");

	a_tp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tp_q <= bftm_pkg::TP_LAST)
		else $error("tape pointer left the tape");
`endif

endmodule

[src/bftm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftm_ctrl
// Controller of the tape machine: input and output handshakes, tape clearing
// sweep, operation sequencing and the dump loop.
// ----------------------------------------------------------------------------
module bftm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            func,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  bftm_pkg::bftm_stat_t  stat,
	output bftm_pkg::bftm_cmd_t   cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_OP   = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;
	localparam logic [2:0] S_DRD  = 3'd5;
	localparam logic [2:0] S_DOUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic       pend_q, pend_d;
	logic       m_tvalid_q, m_tvalid_d;
	logic       accept;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d    = state_q;
		pend_d     = pend_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		cmd        = '0;
		cmd.capture = accept;
		case (state_q)
			S_CLR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = pend_q ? S_RESP : S_IDLE;
					pend_d  = 1'b0;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (func == bftm_pkg::FN_CLEAR) begin
						state_d = S_CLR;
						pend_d  = 1'b1;
					end else begin
						state_d = S_OP;
					end
				end
			end
			S_OP: begin
				cmd.op = 1'b1;
				if (stat.need_link) begin
					state_d = S_LINK;
				end else if (stat.dump) begin
					state_d = S_DRD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DRD: begin
				cmd.dump_rd = 1'b1;
				state_d     = S_DOUT;
			end
			S_DOUT: begin
				cmd.dump_rd = 1'b1;
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_dump = 1'b1;
					m_tvalid_d   = 1'b1;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.dump_inc = 1'b1;
						state_d      = S_DRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_q     <= pend_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register loaded while a result was still held");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item accepted before the first finished");

	a_sweep_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !cmd.out_load && !cmd.op)
		else $error("tape sweep overlapped other work");
`endif

endmodule

[src/brainfuck_tape_machine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_tape_machine_unit
// Byte-tape interpreter with program, input, bracket match and tape memories.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: func in s_tuser[1:0] (load program character,
// load input byte, execute one instruction, clear) and the character or byte
// in s_tdata[7:0]. Results leave on the m_ stream: the printed byte in
// m_tdata, has_byte and status in m_tuser, and tlast on the final result of
// an item. One item is handled at a time; s_tready is high only when idle.
// A load or execute result is registered in the operate state and loaded
// into the output register in the respond state; a closing bracket load
// passes a link state between them. The next item can be taken once the
// result is loaded; a dump alternates a read state and an output state per
// cell. Each step is bound by the registered read of the tape, program and
// match memories followed by the tape write. After reset, and for a clear
// item, a sweep zeroes the tape one cell per cycle while s_tready stays low;
// a clear item's result follows the sweep. If the receiver stalls, the result
// waits in the output register and the block holds, still able to take the
// next item once the current one has handed its last result to that register.
// ----------------------------------------------------------------------------
module brainfuck_tape_machine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [0] has_byte, [2:1] status
	output logic        m_tlast
);

	bftm_pkg::bftm_cmd_t  cmd;
	bftm_pkg::bftm_stat_t stat;

	bftm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bftm_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_bits ({s_tdata, s_tuser}),
		.stat    (stat),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

[sim/brainfuck_tape_machine_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_tape_machine_unit_checker
// Watches both streams of the tape machine. It keeps its own copy of the
// tape, the stores and the bracket table, works out the results that each
// accepted item must give, and compares every result that the block hands out
// with the oldest result still owed.
// ----------------------------------------------------------------------------
module brainfuck_tape_machine_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data
	input  logic [1:0]  s_tuser,   // [1:0] func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic [2:0]  m_tuser,   // [0] has_byte, [2:1] status
	input  logic        m_tlast,
	output int          mismatch_count,
	output int          results_owed,
	output logic        machine_halted,
	output logic        machine_jammed
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       is_last;
		logic [1:0] status;
	} tape_result_t;

	logic [7:0]      tape_cells [bftm_pkg::TAPE_CELLS];
	bftm_pkg::tp_t   head;
	logic [7:0]      code [bftm_pkg::PROGRAM_DEPTH];
	bftm_pkg::pc_t   code_len;
	bftm_pkg::pc_t   code_pos;
	bftm_pkg::pa_t   partner [bftm_pkg::PROGRAM_DEPTH];
	bftm_pkg::pa_t   open_stack [bftm_pkg::NEST_LIMIT];
	bftm_pkg::nd_t   open_count;
	logic [7:0]      feed [bftm_pkg::INPUT_DEPTH];
	bftm_pkg::il_t   feed_len;
	bftm_pkg::il_t   feed_pos;
	logic            unmatched;

	tape_result_t expected_results [$];
	int           errors = 0;

	task automatic owe(input logic [7:0] value, input logic has, input logic fin,
			input logic [1:0] st);
		tape_result_t r;
		r = {value, has, fin, st};
		expected_results = {expected_results, r};
	endtask

	task automatic reset_machine();
		for (int i = 0; i < bftm_pkg::TAPE_CELLS; i++) begin
			tape_cells[bftm_pkg::tp_t'(i)] = 8'd0;
		end
		head       = '0;
		code_len   = '0;
		code_pos   = '0;
		open_count = '0;
		feed_len   = '0;
		feed_pos   = '0;
		unmatched  = 1'b0;
	endtask

	task automatic step_machine(input logic [1:0] fn, input logic [7:0] ch);
		bftm_pkg::pa_t at;
		bftm_pkg::pa_t opener;
		bftm_pkg::pc_t nxt;
		logic [7:0]    op;
		logic [1:0]    st;
		case (fn)
		bftm_pkg::FN_LOADP: begin
			at = code_len[bftm_pkg::PA_W-1:0];
			st = bftm_pkg::ST_OK;
			if (code_len == bftm_pkg::PROG_FULL) begin
				st = bftm_pkg::ST_FULL;
			end else if (ch == bftm_pkg::CH_LBR && open_count == bftm_pkg::NEST_FULL) begin
				st = bftm_pkg::ST_FULL;
			end else begin
				if (ch == bftm_pkg::CH_LBR) begin
					open_stack[open_count[bftm_pkg::NA_W-1:0]] = at;
					open_count = open_count + 1'b1;
				end else if (ch == bftm_pkg::CH_RBR) begin
					if (open_count == '0) begin
						// A closing bracket with nothing open is still stored, but
						// execution stays blocked until the next clear.
						unmatched   = 1'b1;
						partner[at] = '0;
						st          = bftm_pkg::ST_MISMATCH;
					end else begin
						open_count      = open_count - 1'b1;
						opener          = open_stack[open_count[bftm_pkg::NA_W-1:0]];
						partner[at]     = opener;
						partner[opener] = at;
					end
				end
				code[at] = ch;
				code_len = code_len + 1'b1;
			end
			owe(8'd0, 1'b0, 1'b1, st);
		end
		bftm_pkg::FN_LOADI: begin
			if (feed_len == bftm_pkg::IN_FULL) begin
				owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_FULL);
			end else begin
				feed[feed_len[bftm_pkg::IA_W-1:0]] = ch;
				feed_len = feed_len + 1'b1;
				owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_OK);
			end
		end
		bftm_pkg::FN_CLEAR: begin
			reset_machine();
			owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_OK);
		end
		bftm_pkg::FN_EXEC: begin
			if (unmatched || open_count != '0) begin
				owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_MISMATCH);
			end else if (code_pos >= code_len) begin
				owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_END);
			end else begin
				at  = code_pos[bftm_pkg::PA_W-1:0];
				op  = code[at];
				nxt = code_pos + 1'b1;
				case (op)
				bftm_pkg::CH_LT: head = (head == '0) ? bftm_pkg::TP_LAST : head - 1'b1;
				bftm_pkg::CH_GT: head = (head == bftm_pkg::TP_LAST) ? '0 : head + 1'b1;
				bftm_pkg::CH_PLUS: tape_cells[head] = tape_cells[head] + 8'd1;
				bftm_pkg::CH_MINUS: tape_cells[head] = tape_cells[head] - 8'd1;
				bftm_pkg::CH_COMMA: begin
					// Once the input is used up the cell reads as zero and the
					// read position stays where it is.
					if (feed_pos < feed_len) begin
						tape_cells[head] = feed[feed_pos[bftm_pkg::IA_W-1:0]];
						feed_pos = feed_pos + 1'b1;
					end else begin
						tape_cells[head] = 8'd0;
					end
				end
				bftm_pkg::CH_LBR: begin
					if (tape_cells[head] == 8'd0) begin
						nxt = bftm_pkg::pc_t'(partner[at]) + 1'b1;
					end
				end
				bftm_pkg::CH_RBR: begin
					if (tape_cells[head] != 8'd0) begin
						nxt = bftm_pkg::pc_t'(partner[at]) + 1'b1;
					end
				end
				default: ;
				endcase
				code_pos = nxt;
				if (op == bftm_pkg::CH_DOT) begin
					owe(tape_cells[head], 1'b1, 1'b1, bftm_pkg::ST_OK);
				end else if (op == bftm_pkg::CH_HASH) begin
					for (int i = 0; i < bftm_pkg::DUMP_CELLS; i++) begin
						owe(tape_cells[bftm_pkg::tp_t'(i)], 1'b1,
							i == bftm_pkg::DUMP_CELLS - 1, bftm_pkg::ST_OK);
					end
				end else begin
					owe(8'd0, 1'b0, 1'b1, bftm_pkg::ST_OK);
				end
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tape_result_t got;
		tape_result_t want;
		if (!arst_n) begin
			reset_machine();
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]};
				if (expected_results.size() == 0) begin
					$error("result with nothing owed: out_byte %0d, status %0d",
						got.out_byte, got.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
						errors++;
					end
					if (got.has_byte !== want.has_byte) begin
						$error("has_byte: expected %0d, got %0d", want.has_byte, got.has_byte);
						errors++;
					end
					if (got.is_last !== want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, got.is_last);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				step_machine(s_tuser, s_tdata);
			end
		end
		mismatch_count <= errors;
		results_owed   <= expected_results.size();
		machine_jammed <= unmatched || open_count != '0;
		machine_halted <= unmatched || open_count != '0 || code_pos >= code_len;
	end

endmodule

[sim/brainfuck_tape_machine_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_tape_machine_unit_test
// Drives the tape machine with a short hand-made program, then with random
// sessions of input bytes, mostly well-formed program pieces and execute
// batches, and finally overflows the bracket stack. Bursty input and an
// irregular receiver stall the streams; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module brainfuck_tape_machine_unit_test;

	localparam int RANDOM_ITEMS  = 400;
	localparam int QUIET_LIMIT   = 200000;  // well above the length of the tape sweep
	localparam int SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data
	logic [1:0]  s_tuser = '0;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] out_byte
	logic [2:0]  m_tuser;        // [0] has_byte, [2:1] status
	logic        m_tlast;

	int   mismatch_count;
	int   results_owed;
	logic machine_halted;
	logic machine_jammed;

	int         burst_left = 0;
	int         items_sent = 0;
	int         quiet_cycles = 0;
	int         stall_left = 0;
	int         stall_mode = 0;
	logic [7:0] chunk [$];

	brainfuck_tape_machine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	brainfuck_tape_machine_unit_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.machine_halted (machine_halted),
		.machine_jammed (machine_jammed)
	);

	always #6 clk = ~clk;

	// The receiver switches now and then between always ready, mostly ready,
	// mostly stalled and a regular pattern of long stalls.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= ($urandom_range(0, 3) != 0);
		2: m_tready <= ($urandom_range(0, 3) == 0);
		default: m_tready <= (stall_left % 12 < 4);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic is_instruction(input logic [7:0] ch);
		case (ch)
		bftm_pkg::CH_LT, bftm_pkg::CH_GT, bftm_pkg::CH_PLUS, bftm_pkg::CH_MINUS,
		bftm_pkg::CH_COMMA, bftm_pkg::CH_DOT, bftm_pkg::CH_HASH, bftm_pkg::CH_LBR,
		bftm_pkg::CH_RBR:
			return 1'b1;
		default:
			return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pick_filler();
		logic [7:0] ch;
		do ch = 8'($urandom_range(0, 255)); while (is_instruction(ch));
		return ch;
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 7))
		0: return bftm_pkg::CH_LT;
		1: return bftm_pkg::CH_GT;
		2: return bftm_pkg::CH_PLUS;
		3: return bftm_pkg::CH_MINUS;
		4: return bftm_pkg::CH_COMMA;
		5: return bftm_pkg::CH_DOT;
		6: return bftm_pkg::CH_HASH;
		default: return pick_filler();
		endcase
	endfunction

	// Characters that leave both the pointer and the cell alone.
	function automatic logic [7:0] pick_quiet();
		case ($urandom_range(0, 2))
		0: return bftm_pkg::CH_DOT;
		1: return bftm_pkg::CH_HASH;
		default: return pick_filler();
		endcase
	endfunction

	task automatic append_char(input logic [7:0] ch);
		chunk = {chunk, ch};
	endtask

	task automatic push_item(input logic [1:0] fn, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= fn;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// Executes in short batches until the machine stops or the step budget
	// runs out; a batch may run past the program end on purpose.
	task automatic run_program(input int cap);
		int steps;
		int n;
		steps = 0;
		do begin
			n = $urandom_range(1, 8);
			repeat (n) push_item(bftm_pkg::FN_EXEC, 8'($urandom_range(0, 255)));
			steps += n;
			drain();
		end while (!machine_halted && steps < cap);
	endtask

	task automatic load_chunk();
		foreach (chunk[i]) begin
			push_item(bftm_pkg::FN_LOADP, chunk[i]);
		end
		chunk.delete();
	endtask

	task automatic add_piece();
		case ($urandom_range(0, 5))
		0, 1: append_char(pick_op());
		2: begin
			// Counted loop: each pass takes one off the cell, so it ends once
			// the preset count is used up.
			repeat ($urandom_range(1, 4)) append_char(bftm_pkg::CH_PLUS);
			append_char(bftm_pkg::CH_LBR);
			append_char(bftm_pkg::CH_MINUS);
			repeat ($urandom_range(0, 2)) append_char(pick_quiet());
			if ($urandom_range(0, 1) == 1) begin
				// Nested loop that moves the rest of the count one cell right.
				append_char(bftm_pkg::CH_LBR);
				append_char(bftm_pkg::CH_MINUS);
				append_char(bftm_pkg::CH_GT);
				append_char(bftm_pkg::CH_PLUS);
				append_char(bftm_pkg::CH_LT);
				append_char(bftm_pkg::CH_RBR);
			end
			append_char(bftm_pkg::CH_RBR);
		end
		3: begin
			// Zero the cell, then a loop whose body is always jumped over.
			append_char(bftm_pkg::CH_LBR);
			append_char(bftm_pkg::CH_MINUS);
			append_char(bftm_pkg::CH_RBR);
			append_char(bftm_pkg::CH_LBR);
			repeat ($urandom_range(1, 3)) append_char(pick_op());
			append_char(bftm_pkg::CH_RBR);
		end
		4: append_char(($urandom_range(0, 1) == 1) ? bftm_pkg::CH_DOT : bftm_pkg::CH_HASH);
		default: begin
			repeat ($urandom_range(1, 3)) begin
				append_char(($urandom_range(0, 1) == 1) ? bftm_pkg::CH_LT : bftm_pkg::CH_GT);
			end
		end
		endcase
	endtask

	initial begin : stimulus
		logic [7:0] demo [13];
		int         start;
		int         clears_left;
		int         form;

		demo = '{bftm_pkg::CH_LT, bftm_pkg::CH_GT, bftm_pkg::CH_PLUS, bftm_pkg::CH_GT,
			bftm_pkg::CH_COMMA, bftm_pkg::CH_PLUS, bftm_pkg::CH_MINUS, bftm_pkg::CH_DOT,
			bftm_pkg::CH_COMMA, bftm_pkg::CH_COMMA, bftm_pkg::CH_LBR, bftm_pkg::CH_RBR,
			bftm_pkg::CH_HASH};
		// Start with '<' '+' '>' so the pointer wraps both ways.
		demo[1] = bftm_pkg::CH_PLUS;
		demo[2] = bftm_pkg::CH_GT;
		demo[3] = bftm_pkg::CH_COMMA;
		demo[4] = bftm_pkg::CH_PLUS;
		demo[5] = bftm_pkg::CH_MINUS;
		demo[6] = bftm_pkg::CH_DOT;
		demo[7] = bftm_pkg::CH_COMMA;
		demo[8] = bftm_pkg::CH_COMMA;
		demo[9] = bftm_pkg::CH_LBR;
		demo[10] = bftm_pkg::CH_PLUS;
		demo[11] = bftm_pkg::CH_RBR;
		demo[12] = bftm_pkg::CH_HASH;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Hand-made program: both pointer wraps, cell wrap up and down, reads
		// of 0xFF, 0x00 and past the end of input, a print, a skipped loop and
		// a dump, then an unknown character and execution past the end.
		push_item(bftm_pkg::FN_EXEC, 8'h00);
		push_item(bftm_pkg::FN_LOADI, 8'hFF);
		push_item(bftm_pkg::FN_LOADI, 8'h00);
		foreach (demo[i]) begin
			push_item(bftm_pkg::FN_LOADP, demo[i]);
		end
		push_item(bftm_pkg::FN_LOADP, pick_filler());
		run_program(20);
		push_item(bftm_pkg::FN_LOADP, bftm_pkg::CH_RBR);
		push_item(bftm_pkg::FN_EXEC, 8'h00);
		push_item(bftm_pkg::FN_CLEAR, 8'hFF);
		drain();

		start = items_sent;
		clears_left = 6;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (clears_left > 0 && (machine_jammed || $urandom_range(0, 5) == 0)) begin
				push_item(bftm_pkg::FN_CLEAR, 8'($urandom_range(0, 255)));
				clears_left--;
			end
			repeat ($urandom_range(0, 4)) begin
				push_item(bftm_pkg::FN_LOADI, 8'($urandom_range(0, 255)));
			end
			form = $urandom_range(0, 9);
			if (form == 0 && clears_left > 0) begin
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 3) == 0) begin
						append_char(($urandom_range(0, 1) == 1) ? bftm_pkg::CH_LBR
							: bftm_pkg::CH_RBR);
					end else begin
						append_char(8'($urandom_range(0, 255)));
					end
				end
			end else begin
				repeat ($urandom_range(1, 6)) add_piece();
				if (form == 1 && clears_left > 0) begin
					// A stray bracket that never gets its partner.
					if ($urandom_range(0, 1) == 1) begin
						chunk.push_front(bftm_pkg::CH_RBR);
					end else begin
						append_char(bftm_pkg::CH_LBR);
					end
				end
			end
			load_chunk();
			run_program($urandom_range(8, 60));
		end

		// Overflow the bracket stack.
		push_item(bftm_pkg::FN_CLEAR, 8'h00);
		repeat (bftm_pkg::NEST_LIMIT + 1) push_item(bftm_pkg::FN_LOADP, bftm_pkg::CH_LBR);
		push_item(bftm_pkg::FN_EXEC, 8'h00);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[sim.f]
src/bftm_pkg.sv
src/bftm_dpath.sv
src/bftm_ctrl.sv
src/brainfuck_tape_machine_unit.sv
sim/brainfuck_tape_machine_unit_checker.sv
sim/brainfuck_tape_machine_unit_test.sv
